[hw/rtl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// shared constants, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int PCC_ARG_WIDTH   = 16;
    localparam int PCC_COUNT_WIDTH = 64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DOMAIN   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        OP_PERM = 1'b0,
        OP_COMB = 1'b1
    } t_op;

    typedef struct packed {
        logic load;
        logic mul_init;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic dom;
        logic comb;
        logic loop_done;
        logic cnt_zero;
        logic ovf;
    } t_dp_stat;

endpackage

[hw/rtl/permutation_and_combination_count_core.sv]
// ----------------------------------------------------------------------------
// permutation_and_combination_count_core
// exact nPr / nCr counter with saturation and domain checking
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry one word of operation, n and r
// (signed). output channel: o_out_valid / i_out_ready carry count and status.
// one word is in work at a time; o_in_ready is high only while idle.
// each loop step is a shift-add multiply (its last state commits for nPr),
// for a combination a restoring divide ending in the commit, and a state to
// pick the next step. steps run at most min(r, n-r) times for nCr or r times
// for nPr, and the loop stops early on overflow. domain errors and empty
// choices skip the loop and go straight to the finishing state. o_in_ready
// rises with o_out_valid, so a new word is taken only once the previous
// result is presented.
// the finished word sits in an output register; if the receiver stalls the
// core takes one more word, holds its result until that register drains and
// keeps o_in_ready low meanwhile.
// reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid.
// ----------------------------------------------------------------------------
module permutation_and_combination_count_core import pcc_pkg::*; #(
    parameter int ARG_WIDTH   = PCC_ARG_WIDTH,
    parameter int COUNT_WIDTH = PCC_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  logic [ARG_WIDTH-1:0]   i_n,
    input  logic [ARG_WIDTH-1:0]   i_r,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [1:0]             o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    pcc_datapath #(
        .ARG_WIDTH   (ARG_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_operation),
        .i_n         (i_n),
        .i_r         (i_r),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    a_domain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DOMAIN) |-> (o_count == '0))
        else $error("domain error word with non-zero count");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OVERFLOW) |-> (o_count == '1))
        else $error("overflow word not saturated");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in work");

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && o_out_valid) |-> i_out_ready)
        else $error("output word overwritten before it was taken");

endmodule

[hw/rtl/pcc_datapath.sv]
// ----------------------------------------------------------------------------
// pcc_datapath
// accumulator, shift-add multiplier, restoring divider and result register
// ----------------------------------------------------------------------------
module pcc_datapath import pcc_pkg::*; #(
    parameter int ARG_WIDTH   = PCC_ARG_WIDTH,
    parameter int COUNT_WIDTH = PCC_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_operation,
    input  logic [ARG_WIDTH-1:0]   i_n,
    input  logic [ARG_WIDTH-1:0]   i_r,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [1:0]             o_status
);

    localparam int PW   = COUNT_WIDTH + ARG_WIDTH;
    localparam int CNTW = $clog2(PW + 1);

    logic                   r_op;
    logic                   r_dom;
    logic                   r_ovf;
    logic [ARG_WIDTH-1:0]   r_n;
    logic [ARG_WIDTH-1:0]   r_lim;
    logic [ARG_WIDTH-1:0]   r_i;
    logic [ARG_WIDTH-1:0]   r_f;
    logic [ARG_WIDTH-1:0]   r_dvs;
    logic [ARG_WIDTH-1:0]   r_rem;
    logic [COUNT_WIDTH-1:0] r_acc;
    logic [PW-1:0]          r_prod;
    logic [CNTW-1:0]        r_cnt;
    logic [COUNT_WIDTH-1:0] r_count;
    t_status                r_status;

    logic                 in_dom;
    logic [ARG_WIDTH-1:0] in_nmr;
    logic [ARG_WIDTH-1:0] in_lim;
    logic [ARG_WIDTH:0]   div_try;
    logic [ARG_WIDTH:0]   div_sub;
    logic                 div_bit;
    logic                 prod_ovf;

    always_comb begin
        in_dom = i_n[ARG_WIDTH-1] | i_r[ARG_WIDTH-1] | ($signed(i_r) > $signed(i_n));
        in_nmr = i_n - i_r;
        if (i_operation == OP_COMB && in_nmr < i_r) begin
            in_lim = in_nmr;
        end else begin
            in_lim = i_r;
        end
    end

    // one quotient bit of the restoring divide
    always_comb begin
        div_try = {r_rem, r_prod[PW-1]};
        div_sub = div_try - {1'b0, r_dvs};
        div_bit = (div_try >= {1'b0, r_dvs});
    end

    assign prod_ovf = (r_prod[PW-1:COUNT_WIDTH] != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_dom <= in_dom;
            r_ovf <= 1'b0;
            r_n   <= i_n;
            r_lim <= in_lim;
            r_i   <= '0;
            r_acc <= COUNT_WIDTH'(1);
        end
        if (i_cmd.mul_init) begin
            r_prod <= '0;
            r_f    <= r_n - r_i;
            r_cnt  <= CNTW'(ARG_WIDTH);
        end
        if (i_cmd.mul_step) begin
            r_prod <= {r_prod[PW-2:0], 1'b0}
                      + (r_f[ARG_WIDTH-1] ? {{ARG_WIDTH{1'b0}}, r_acc} : '0);
            r_f    <= {r_f[ARG_WIDTH-2:0], 1'b0};
            r_cnt  <= r_cnt - CNTW'(1);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dvs <= r_i + ARG_WIDTH'(1);
            r_cnt <= CNTW'(PW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_bit ? div_sub[ARG_WIDTH-1:0] : div_try[ARG_WIDTH-1:0];
            r_prod <= {r_prod[PW-2:0], div_bit};
            r_cnt  <= r_cnt - CNTW'(1);
        end
        if (i_cmd.commit) begin
            if (prod_ovf) begin
                r_ovf <= 1'b1;
            end else begin
                r_acc <= r_prod[COUNT_WIDTH-1:0];
                r_i   <= r_i + ARG_WIDTH'(1);
            end
        end
        if (i_cmd.emit) begin
            if (r_dom) begin
                r_count  <= '0;
                r_status <= ST_DOMAIN;
            end else if (r_ovf) begin
                r_count  <= '1;
                r_status <= ST_OVERFLOW;
            end else begin
                r_count  <= r_acc;
                r_status <= ST_OK;
            end
        end
    end

    always_comb begin
        o_stat.dom       = r_dom;
        o_stat.comb      = (r_op == OP_COMB);
        o_stat.loop_done = (r_i == r_lim);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.ovf       = r_ovf;
    end

    assign o_count  = r_count;
    assign o_status = r_status;

endmodule

[hw/rtl/pcc_ctrl.sv]
// ----------------------------------------------------------------------------
// pcc_ctrl
// sequencer for the multiply-divide loop and the handshakes
// ----------------------------------------------------------------------------
module pcc_ctrl import pcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_NEXT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.dom || i_stat.loop_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_init = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                if (!i_stat.cnt_zero) begin
                    o_cmd.mul_step = 1'b1;
                end else if (i_stat.comb) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_NEXT;
                end
            end
            S_DIV: begin
                if (!i_stat.cnt_zero) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.ovf || i_stat.loop_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_init = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_FIN: begin
                // wait for the output word to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
